/* hw/rtl/gradient_magnitude_orientation_macros.svh */
// Assertion helpers shared by the gradient block
`ifndef GRADIENT_MAGNITUDE_ORIENTATION_MACROS_SVH
`define GRADIENT_MAGNITUDE_ORIENTATION_MACROS_SVH

// Checked only outside reset
`define GMO_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included
`define GMO_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* hw/rtl/gmo_pkg.sv */
package gmo_pkg;

   // Default sizes
   localparam int unsigned MAX_WIDTH_DEF  = 2048;
   localparam int unsigned MAX_HEIGHT_DEF = 2048;
   localparam int unsigned PIXEL_BITS_DEF = 16;
   localparam int unsigned ANGLE_BITS_DEF = 16;

   // Configuration registers
   localparam int unsigned DIM_BITS       = 12;
   localparam int unsigned CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 1'd1;
   localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 12'd640;
   localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 12'd480;
   localparam int unsigned MIN_DIM = 3;

   // CORDIC: angles in 2^-32 turn
   localparam int unsigned CORDIC_STEPS = 30;
   localparam int unsigned STEP_BITS    = $clog2(CORDIC_STEPS);
   localparam int unsigned PRESHIFT     = 32;
   localparam int unsigned ZW           = 34;
   localparam int unsigned TW           = 31;
   localparam logic [TW-1:0] QUARTER_TURN = 31'h4000_0000;

   // atan(2^-i)
   localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1
   };

   // Saturate a dimension register to [3, hi]
   function automatic logic [31:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                             input int unsigned hi);
      logic [31:0] vv;
      vv = 32'(v);
      if (vv < MIN_DIM) begin
         return 32'(MIN_DIM);
      end else if (vv > hi) begin
         return hi;
      end
      return vv;
   endfunction

endpackage

/* hw/rtl/gradient_magnitude_orientation.sv */
// Gradient magnitude and orientation of a raster-order greyscale frame.
// Request channel: req_valid/req_stall carry one pixel per request.
// Response channel: rsp_valid/rsp_stall carry magnitude, orientation,
// last_of_run and frame_done. A response for pixel (r-1,c) is produced by
// the request of pixel (r,c); row 0 requests produce nothing and last-row
// requests add their own border response.
// Configuration: csr_write with csr_index/csr_wdata sets frame width and
// height; write only while no request is in flight.
// One request is processed at a time: two line-store reads, a write-back,
// two squaring steps, then the CORDIC running alongside a one-bit-per-cycle
// square root, then the response register. req_stall stays high from
// accept until the last response is taken. Requests that produce nothing
// free the block after the write-back.
// A stalled response holds its payload; the block waits for it.
// Reset clears the counters and control; line stores are not cleared.
`include "gradient_magnitude_orientation_macros.svh"

module gradient_magnitude_orientation #(
   parameter int unsigned MAX_WIDTH  = gmo_pkg::MAX_WIDTH_DEF,
   parameter int unsigned MAX_HEIGHT = gmo_pkg::MAX_HEIGHT_DEF,
   parameter int unsigned PIXEL_BITS = gmo_pkg::PIXEL_BITS_DEF,
   parameter int unsigned ANGLE_BITS = gmo_pkg::ANGLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [PIXEL_BITS-1:0]               req_pixel,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [PIXEL_BITS:0]                 rsp_magnitude,
   output logic [ANGLE_BITS:0]                 rsp_orientation,
   output logic                                rsp_last_of_run,
   output logic                                rsp_frame_done,
   input  logic                                csr_write,
   input  logic [gmo_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [gmo_pkg::DIM_BITS-1:0]        csr_wdata
);

   localparam int unsigned AW  = $clog2(MAX_WIDTH);
   localparam int unsigned CW  = $clog2(MAX_WIDTH + 1);
   localparam int unsigned RW  = $clog2(MAX_HEIGHT + 1);
   localparam int unsigned MW  = PIXEL_BITS + 1;
   localparam int unsigned OW  = ANGLE_BITS + 1;
   localparam int unsigned SQW = 2 * PIXEL_BITS + 2;
   localparam int unsigned XW  = PIXEL_BITS + gmo_pkg::PRESHIFT + 3;
   localparam int unsigned ZW  = gmo_pkg::ZW;
   localparam int unsigned TW  = gmo_pkg::TW;
   localparam int unsigned SW  = gmo_pkg::STEP_BITS;
   localparam logic [OW-1:0] HALF_TURN = OW'(1) << (ANGLE_BITS - 1);

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_RD0  = 9'b000000010,
      S_RD1  = 9'b000000100,
      S_WR   = 9'b000001000,
      S_SQ   = 9'b000010000,
      S_SUM  = 9'b000100000,
      S_CALC = 9'b001000000,
      S_FIN  = 9'b010000000,
      S_OUT  = 9'b100000000
   } state_type;

   typedef struct packed {
      logic emit_first;
      logic last_row;
      logic interior;
      logic left_ok;
      logic right_ok;
      logic frame_end;
   } item_flags_type;

   state_type state_ff, state_in;

   // Configuration
   logic [gmo_pkg::DIM_BITS-1:0] width_ff, height_ff;
   logic [CW-1:0] w_dim;
   logic [RW-1:0] h_dim;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= gmo_pkg::WIDTH_RESET;
         height_ff <= gmo_pkg::HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            gmo_pkg::CSR_FRAME_WIDTH:  width_ff  <= csr_wdata;
            gmo_pkg::CSR_FRAME_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign w_dim = CW'(gmo_pkg::clamp_dim(width_ff, MAX_WIDTH));
   assign h_dim = RW'(gmo_pkg::clamp_dim(height_ff, MAX_HEIGHT));

   // Raster position, with wrap on a size change
   logic [CW-1:0] col_ff, col_in, c_cur, c_ff;
   logic [RW-1:0] row_ff, row_in, r_cur;
   logic [RW:0]   r_tmp, r_nx;
   logic [CW:0]   c_nx;
   item_flags_type flags_cur, flags_ff;
   logic [PIXEL_BITS-1:0] pix_ff;
   logic req_accept;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);

   always_comb begin
      c_cur = col_ff;
      r_tmp = {1'b0, row_ff};
      if (col_ff >= w_dim) begin
         c_cur = '0;
         r_tmp = r_tmp + 1'b1;
      end
      if (r_tmp >= {1'b0, h_dim}) begin
         r_tmp = '0;
      end
      r_cur = r_tmp[RW-1:0];
      c_nx  = {1'b0, c_cur} + 1'b1;
      r_nx  = {1'b0, r_cur} + 1'b1;
      if (c_nx >= {1'b0, w_dim}) begin
         col_in = '0;
         row_in = (r_nx >= {1'b0, h_dim}) ? '0 : r_nx[RW-1:0];
      end else begin
         col_in = c_nx[CW-1:0];
         row_in = r_cur;
      end
      flags_cur.emit_first = (r_cur != '0);
      flags_cur.last_row   = (r_nx == {1'b0, h_dim});
      flags_cur.interior   = (r_cur >= RW'(2)) && (c_cur != '0) &&
                             ({1'b0, c_cur} + (CW+1)'(2) <= {1'b0, w_dim});
      flags_cur.left_ok    = (c_cur != '0);
      flags_cur.right_ok   = (c_nx < {1'b0, w_dim});
      flags_cur.frame_end  = (c_nx == {1'b0, w_dim});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         c_ff     <= c_cur;
         flags_ff <= flags_cur;
         pix_ff   <= req_pixel;
      end
   end

   // Line stores: read c, then c-1 / c+1, then write back at c
   logic [PIXEL_BITS-1:0] older_mem [MAX_WIDTH];
   logic [PIXEL_BITS-1:0] newer_mem [MAX_WIDTH];
   logic [PIXEL_BITS-1:0] older_q_ff, newer_q_ff, up_ff, newer_c_ff;
   logic [CW-1:0] c_m1, c_p1;
   logic [AW-1:0] older_raddr, newer_raddr;

   assign c_m1 = c_ff - 1'b1;
   assign c_p1 = c_ff + 1'b1;
   assign older_raddr = (state_ff == S_RD0) ? c_ff[AW-1:0] : c_m1[AW-1:0];
   assign newer_raddr = (state_ff == S_RD0) ? c_ff[AW-1:0] : c_p1[AW-1:0];

   always_ff @(posedge clock) begin
      if (state_ff == S_RD0 || state_ff == S_RD1) begin
         older_q_ff <= older_mem[older_raddr];
         newer_q_ff <= newer_mem[newer_raddr];
      end
      if (state_ff == S_WR) begin
         older_mem[c_ff[AW-1:0]] <= newer_c_ff;
         newer_mem[c_ff[AW-1:0]] <= pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_RD1) begin
         up_ff      <= older_q_ff;
         newer_c_ff <= newer_q_ff;
      end
   end

   // Central differences
   logic [PIXEL_BITS-1:0] left_pix, right_pix;
   logic [PIXEL_BITS:0]   dx_s, dy_s, dx_n, dy_n;
   logic [PIXEL_BITS-1:0] adx_ff, ady_ff;
   logic                  dxneg_ff, dyneg_ff;

   assign left_pix  = flags_ff.left_ok  ? older_q_ff : '0;
   assign right_pix = flags_ff.right_ok ? newer_q_ff : '0;
   assign dx_s = {1'b0, right_pix} - {1'b0, left_pix};
   assign dy_s = {1'b0, pix_ff} - {1'b0, up_ff};
   assign dx_n = -dx_s;
   assign dy_n = -dy_s;

   always_ff @(posedge clock) begin
      if (state_ff == S_WR) begin
         dxneg_ff <= dx_s[PIXEL_BITS];
         dyneg_ff <= dy_s[PIXEL_BITS];
         adx_ff   <= dx_s[PIXEL_BITS] ? dx_n[PIXEL_BITS-1:0] : dx_s[PIXEL_BITS-1:0];
         ady_ff   <= dy_s[PIXEL_BITS] ? dy_n[PIXEL_BITS-1:0] : dy_s[PIXEL_BITS-1:0];
      end
   end

   // Sum of squares, one multiply per cycle
   logic [2*PIXEL_BITS-1:0] sq_ff, ady_sq;
   assign ady_sq = ady_ff * ady_ff;

   always_ff @(posedge clock) begin
      if (state_ff == S_SQ) begin
         sq_ff <= adx_ff * adx_ff;
      end
   end

   // Square root, one result bit per cycle
   logic [SQW-1:0] sqrt_s_ff, sqrt_r_ff, sqrt_bit_ff, sqrt_trial;
   assign sqrt_trial = sqrt_r_ff + sqrt_bit_ff;

   always_ff @(posedge clock) begin
      if (state_ff == S_SUM) begin
         sqrt_s_ff   <= SQW'(sq_ff) + SQW'(ady_sq);
         sqrt_r_ff   <= '0;
         sqrt_bit_ff <= SQW'(1) << (SQW - 2);
      end else if (state_ff == S_CALC && sqrt_bit_ff != '0) begin
         if (sqrt_s_ff >= sqrt_trial) begin
            sqrt_s_ff <= sqrt_s_ff - sqrt_trial;
            sqrt_r_ff <= (sqrt_r_ff >> 1) + sqrt_bit_ff;
         end else begin
            sqrt_r_ff <= sqrt_r_ff >> 1;
         end
         sqrt_bit_ff <= sqrt_bit_ff >> 2;
      end
   end

   // CORDIC vectoring in the first quadrant, one step per cycle
   logic signed [XW-1:0] x_ff, y_ff, xs, ys;
   logic signed [ZW-1:0] z_ff, atan_step;
   logic [SW-1:0]        step_ff;

   assign xs = x_ff >>> step_ff;
   assign ys = y_ff >>> step_ff;
   assign atan_step = $signed(ZW'(gmo_pkg::ATAN_TAB[step_ff]));

   always_ff @(posedge clock) begin
      if (state_ff == S_WR) begin
         x_ff    <= $signed(XW'(dx_s[PIXEL_BITS] ? dx_n[PIXEL_BITS-1:0]
                                                 : dx_s[PIXEL_BITS-1:0]) << gmo_pkg::PRESHIFT);
         y_ff    <= $signed(XW'(dy_s[PIXEL_BITS] ? dy_n[PIXEL_BITS-1:0]
                                                 : dy_s[PIXEL_BITS-1:0]) << gmo_pkg::PRESHIFT);
         z_ff    <= '0;
         step_ff <= '0;
      end else if (state_ff == S_CALC) begin
         if (!y_ff[XW-1]) begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + atan_step;
         end else begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - atan_step;
         end
         step_ff <= step_ff + 1'b1;
      end
   end

   // Final rounding and quadrant fold
   logic [TW-1:0]  t_ang;
   logic [32:0]    a_ang;
   logic [33:0]    a_rnd;
   logic [MW-1:0]  mag_val;
   logic [OW-1:0]  ort_val;
   logic [SQW-1:0] r_up;

   always_comb begin
      if (ady_ff == '0) begin
         t_ang = '0;
      end else if (adx_ff == '0) begin
         t_ang = gmo_pkg::QUARTER_TURN;
      end else if (z_ff[ZW-1]) begin
         t_ang = '0;
      end else if (z_ff > $signed(ZW'(gmo_pkg::QUARTER_TURN))) begin
         t_ang = gmo_pkg::QUARTER_TURN;
      end else begin
         t_ang = z_ff[TW-1:0];
      end
      unique case ({dyneg_ff, dxneg_ff})
         2'b00:   a_ang = 33'h0_8000_0000 + 33'(t_ang);
         2'b01:   a_ang = 33'h1_0000_0000 - 33'(t_ang);
         2'b10:   a_ang = 33'h0_8000_0000 - 33'(t_ang);
         default: a_ang = 33'(t_ang);
      endcase
      a_rnd = 34'(a_ang) + (34'(1) << (31 - ANGLE_BITS));
      r_up  = (sqrt_s_ff > sqrt_r_ff) ? sqrt_r_ff + 1'b1 : sqrt_r_ff;
      if (!flags_ff.interior) begin
         mag_val = '0;
         ort_val = HALF_TURN;
      end else if (adx_ff == '0 && ady_ff == '0) begin
         mag_val = '0;
         ort_val = HALF_TURN;
      end else begin
         mag_val = r_up[MW-1:0];
         ort_val = OW'(a_rnd >> (32 - ANGLE_BITS));
      end
   end

   // Response register
   logic          rsp_valid_ff, second_ff;
   logic [MW-1:0] rsp_mag_ff;
   logic [OW-1:0] rsp_ort_ff;
   logic          rsp_last_ff, rsp_done_ff;
   logic          rsp_accept;

   assign rsp_accept = rsp_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else if (state_ff == S_FIN) begin
         rsp_valid_ff <= 1'b1;
         second_ff    <= flags_ff.emit_first && flags_ff.last_row;
      end else if (rsp_accept) begin
         rsp_valid_ff <= second_ff;
         second_ff    <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_FIN && flags_ff.emit_first) begin
         rsp_mag_ff  <= mag_val;
         rsp_ort_ff  <= ort_val;
         rsp_last_ff <= !flags_ff.last_row;
         rsp_done_ff <= 1'b0;
      end else if (state_ff == S_FIN || (rsp_accept && second_ff)) begin
         // Own border response of a last-row pixel
         rsp_mag_ff  <= '0;
         rsp_ort_ff  <= HALF_TURN;
         rsp_last_ff <= 1'b1;
         rsp_done_ff <= flags_ff.frame_end;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_magnitude   = rsp_mag_ff;
   assign rsp_orientation = rsp_ort_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_frame_done  = rsp_done_ff;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid) begin
            state_in = S_RD0;
         end
         S_RD0:  state_in = S_RD1;
         S_RD1:  state_in = S_WR;
         S_WR: begin
            if (flags_ff.emit_first || flags_ff.last_row) begin
               state_in = S_SQ;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SQ:   state_in = S_SUM;
         S_SUM:  state_in = S_CALC;
         S_CALC: if (step_ff == SW'(gmo_pkg::CORDIC_STEPS - 1)) begin
            state_in = S_FIN;
         end
         S_FIN:  state_in = S_OUT;
         S_OUT:  if (rsp_accept && !second_ff) begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `GMO_ASSERT(a_rsp_only_in_out, rsp_valid_ff |-> (state_ff == S_OUT), "response outside output state")
   `GMO_ASSERT(a_accept_starts_read, req_accept |=> (state_ff == S_RD0), "accept did not start read")
   `GMO_ASSERT(a_second_not_last, (rsp_valid_ff && second_ff) |-> !rsp_last_ff, "first of two marked last")
   `GMO_ASSERT(a_calc_ends, (state_ff == S_CALC && step_ff == SW'(gmo_pkg::CORDIC_STEPS - 1)) |=> (state_ff == S_FIN), "CORDIC overran")
   `GMO_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_valid_ff, "response valid after reset")

endmodule
